// File: rtl/lrl_pkg.sv
// Package: shared types and constants of the loss driven rate ladder.
package lrl_pkg;

    // Rate index reset values and limits
    localparam logic [3:0] LOW_RESET  = 4'd2;
    localparam logic [3:0] MID_RESET  = 4'd3;
    localparam logic [5:0] HIGH_RESET = 6'd11;
    localparam logic [3:0] LOW_CAP    = 4'd10;
    localparam logic [3:0] MID_CAP    = 4'd11;
    localparam logic [5:0] HIGH_TOP   = 6'd35;   // high index jumps 11 <-> 35
    localparam logic [5:0] HIGH_STEP  = 6'd11;   // last contiguous high index
    localparam logic [16:0] INC_HOLDOFF = 17'd2; // rounds between increases

    // Threshold factors: hi_th = round*7/10, lo_th = round/2
    localparam int HI_NUM = 7;
    localparam int HI_DEN = 10;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Class order in the flag vectors
    localparam int CLS_LOW  = 0;
    localparam int CLS_MID  = 1;
    localparam int CLS_HIGH = 2;

    // Classified report: round and per class loss flags
    typedef struct packed {
        logic [15:0] round;
        logic [2:0]  dn;    // loss > round/2
        logic [2:0]  up;    // loss < round*7/10
    } entry_t;

endpackage

// File: rtl/lrl_if.sv
// Interfaces: loss report channel and rate result channel.
interface lrl_rpt_if;
    logic        valid;
    logic        ready;
    logic [15:0] report_round;
    logic [15:0] loss_low;
    logic [15:0] loss_mid;
    logic [15:0] loss_high;

    modport source (output valid, report_round, loss_low, loss_mid, loss_high,
                    input ready);
    modport sink   (input valid, report_round, loss_low, loss_mid, loss_high,
                    output ready);
endinterface

interface lrl_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] rate_low;
    logic [3:0] rate_mid;
    logic [5:0] rate_high;
    logic       changed;

    modport source (output valid, rate_low, rate_mid, rate_high, changed,
                    input ready);
    modport sink   (input valid, rate_low, rate_mid, rate_high, changed,
                    output ready);
endinterface

// File: rtl/loss_driven_rate_ladder.sv
// Top level: loss driven rate ladder with front classifier, queue and back update.
//
// The block keeps three ordered rate indices (low, mid, high; reset 2, 3, 11)
// and answers every loss report word with one result word holding the indices
// after the update and a flag that tells whether any index moved. A report is
// taken on rpt when valid and ready are both high; the result passes the queue
// and the result register to res and waits there until res.ready. One report
// per cycle is sustained while res.ready stays high: the front compares each
// loss count against the thresholds round*7/10 and round/2 with no division
// (shift-add products and compares), the classified word goes through a short
// queue, and the back applies the ordered decrease (low, mid, high) and increase
// (high, mid, low) checks to its index and round registers together, which is the
// loop that sets the rate. The queue lets the report side keep going while a
// finished result waits on res; rpt.ready drops only when the queue is full.
// Round numbers are compared unsigned; a wrapping round is not handled.
module loss_driven_rate_ladder
#(
    parameter int QUEUE_DEPTH = lrl_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    lrl_rpt_if.sink        rpt,
    lrl_res_if.source      res
);

    lrl_pkg::entry_t front_entry;
    lrl_pkg::entry_t head_entry;
    logic            head_valid;
    logic            head_ready;

    // Front: threshold classification of the incoming word
    lrl_front u_front
    (
        .report_round (rpt.report_round),
        .loss_low     (rpt.loss_low),
        .loss_mid     (rpt.loss_mid),
        .loss_high    (rpt.loss_high),
        .entry        (front_entry)
    );

    // Queue decouples report acceptance from the state update
    lrl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (rpt.valid),
        .push_ready (rpt.ready),
        .push_data  (front_entry),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_data   (head_entry)
    );

    // Back: ladder state and registered result word
    lrl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (head_valid),
        .entry_ready (head_ready),
        .entry       (head_entry),
        .res_valid   (res.valid),
        .res_ready   (res.ready),
        .rate_low    (res.rate_low),
        .rate_mid    (res.rate_mid),
        .rate_high   (res.rate_high),
        .changed     (res.changed)
    );

endmodule

// File: rtl/lrl_front.sv
// Front part: classifies each loss count against the round thresholds.
module lrl_front
(
    input  logic [15:0]          report_round,
    input  logic [15:0]          loss_low,
    input  logic [15:0]          loss_mid,
    input  logic [15:0]          loss_high,
    output lrl_pkg::entry_t      entry
);

    logic [18:0] round_x7;
    logic [15:0] lo_th;

    // loss < floor(7r/10)  <=>  10*(loss+1) <= 7r
    function automatic logic up_hit(input logic [15:0] loss, input logic [18:0] r7);
        logic [16:0] lp1;
        logic [20:0] lp1_x10;
        begin
            lp1     = {1'b0, loss} + 17'd1;
            lp1_x10 = ({4'b0, lp1} << 3) + ({4'b0, lp1} << 1);
            up_hit  = lp1_x10 <= {2'b0, r7};
        end
    endfunction

    always_comb
    begin
        round_x7 = ({3'b0, report_round} << 3) - {3'b0, report_round};
        lo_th    = {1'b0, report_round[15:1]};

        entry.round = report_round;
        entry.dn[lrl_pkg::CLS_LOW]  = loss_low  > lo_th;
        entry.dn[lrl_pkg::CLS_MID]  = loss_mid  > lo_th;
        entry.dn[lrl_pkg::CLS_HIGH] = loss_high > lo_th;
        entry.up[lrl_pkg::CLS_LOW]  = up_hit(loss_low,  round_x7);
        entry.up[lrl_pkg::CLS_MID]  = up_hit(loss_mid,  round_x7);
        entry.up[lrl_pkg::CLS_HIGH] = up_hit(loss_high, round_x7);
    end

endmodule

// File: rtl/lrl_queue.sv
// Queue of classified reports between front and back.
module lrl_queue
#(
    parameter int DEPTH = lrl_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lrl_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lrl_pkg::entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lrl_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/lrl_back.sv
// Back part: ladder state, ordered down/up checks and result register.
module lrl_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            entry_valid,
    output logic            entry_ready,
    input  lrl_pkg::entry_t entry,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [3:0]      rate_low,
    output logic [3:0]      rate_mid,
    output logic [5:0]      rate_high,
    output logic            changed
);

    logic [3:0]  low_reg, low_next;
    logic [3:0]  mid_reg, mid_next;
    logic [5:0]  high_reg, high_next;
    logic [15:0] dec_reg  [3];
    logic [15:0] dec_next [3];
    logic [15:0] inc_reg  [3];
    logic [15:0] inc_next [3];

    logic        res_valid_reg;
    logic [3:0]  rate_low_reg;
    logic [3:0]  rate_mid_reg;
    logic [5:0]  rate_high_reg;
    logic        changed_reg;

    logic        take;
    logic [15:0] rnd;

    assign entry_ready = !res_valid_reg || res_ready;
    assign take        = entry_valid && entry_ready;
    assign rnd         = entry.round;

    // Increase hold-off: last + 2 < round, no wrap
    function automatic logic inc_ok(input logic [15:0] last, input logic [15:0] r);
        inc_ok = ({1'b0, last} + lrl_pkg::INC_HOLDOFF) < {1'b0, r};
    endfunction

    always_comb
    begin
        low_next  = low_reg;
        mid_next  = mid_reg;
        high_next = high_reg;
        dec_next  = dec_reg;
        inc_next  = inc_reg;

        // decreases: low, mid, high
        if (entry.dn[lrl_pkg::CLS_LOW] && low_next != 4'd0
            && dec_reg[lrl_pkg::CLS_LOW] < rnd)
        begin
            low_next = low_next - 4'd1;
            dec_next[lrl_pkg::CLS_LOW] = rnd;
        end
        if (entry.dn[lrl_pkg::CLS_MID]
            && {1'b0, mid_next} > ({1'b0, low_next} + 5'd1)
            && dec_reg[lrl_pkg::CLS_MID] < rnd)
        begin
            mid_next = mid_next - 4'd1;
            dec_next[lrl_pkg::CLS_MID] = rnd;
        end
        if (entry.dn[lrl_pkg::CLS_HIGH]
            && {1'b0, high_next} > ({3'b0, mid_next} + 7'd1)
            && dec_reg[lrl_pkg::CLS_HIGH] < rnd)
        begin
            high_next = (high_next == lrl_pkg::HIGH_TOP) ? lrl_pkg::HIGH_STEP
                                                         : high_next - 6'd1;
            dec_next[lrl_pkg::CLS_HIGH] = rnd;
        end

        // increases: high, mid, low
        if (entry.up[lrl_pkg::CLS_HIGH] && high_next < lrl_pkg::HIGH_TOP
            && inc_ok(inc_reg[lrl_pkg::CLS_HIGH], rnd)
            && rnd != dec_next[lrl_pkg::CLS_HIGH])
        begin
            high_next = (high_next == lrl_pkg::HIGH_STEP) ? lrl_pkg::HIGH_TOP
                                                          : high_next + 6'd1;
            inc_next[lrl_pkg::CLS_HIGH] = rnd;
        end
        if (entry.up[lrl_pkg::CLS_MID]
            && ({3'b0, mid_next} + 7'd1) < {1'b0, high_next}
            && mid_next < lrl_pkg::MID_CAP
            && inc_ok(inc_reg[lrl_pkg::CLS_MID], rnd)
            && rnd != dec_next[lrl_pkg::CLS_MID])
        begin
            mid_next = mid_next + 4'd1;
            inc_next[lrl_pkg::CLS_MID] = rnd;
        end
        if (entry.up[lrl_pkg::CLS_LOW]
            && ({1'b0, low_next} + 5'd1) < {1'b0, mid_next}
            && low_next < lrl_pkg::LOW_CAP
            && inc_ok(inc_reg[lrl_pkg::CLS_LOW], rnd)
            && rnd != dec_next[lrl_pkg::CLS_LOW])
        begin
            low_next = low_next + 4'd1;
            inc_next[lrl_pkg::CLS_LOW] = rnd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= lrl_pkg::LOW_RESET;
            mid_reg       <= lrl_pkg::MID_RESET;
            high_reg      <= lrl_pkg::HIGH_RESET;
            dec_reg       <= '{default: '0};
            inc_reg       <= '{default: '0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                low_reg  <= low_next;
                mid_reg  <= mid_next;
                high_reg <= high_next;
                dec_reg  <= dec_next;
                inc_reg  <= inc_next;
            end
            if (take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rate_low_reg  <= low_next;
            rate_mid_reg  <= mid_next;
            rate_high_reg <= high_next;
            changed_reg   <= (low_next != low_reg) || (mid_next != mid_reg)
                             || (high_next != high_reg);
        end
    end

    assign res_valid = res_valid_reg;
    assign rate_low  = rate_low_reg;
    assign rate_mid  = rate_mid_reg;
    assign rate_high = rate_high_reg;
    assign changed   = changed_reg;

endmodule
